### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/knx_pkg.sv
`default_nettype none

package knx_pkg;

    localparam int KNX_QUEUE_DEPTH = 4;

    localparam logic [7:0] CTRL_BASE = 8'h90;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRIORITY = 2'd0;
    localparam logic [1:0] CFG_REPEAT   = 2'd1;
    localparam logic [1:0] CFG_SOURCE   = 2'd2;

    // Octet positions of a telegram header.
    localparam logic [3:0] IDX_CTRL    = 4'd0;
    localparam logic [3:0] IDX_SRC_HI  = 4'd1;
    localparam logic [3:0] IDX_SRC_LO  = 4'd2;
    localparam logic [3:0] IDX_DST_HI  = 4'd3;
    localparam logic [3:0] IDX_DST_LO  = 4'd4;
    localparam logic [3:0] IDX_LEN     = 4'd5;
    localparam logic [3:0] IDX_APCI_HI = 4'd6;
    localparam logic [3:0] IDX_APCI_LO = 4'd7;
    localparam logic [3:0] IDX_CHECK   = 4'd8;

    // Octet positions of a payload transaction.
    localparam logic [3:0] IDX_PAYLOAD    = 4'd0;
    localparam logic [3:0] IDX_DATA_CHECK = 4'd1;

    typedef struct packed {
        logic [1:0]  priority_cfg;
        logic        repeat_flag;
        logic [15:0] source_address;
    } cfg_t;

    typedef struct packed {
        logic        is_start;
        logic        close;
        logic [7:0]  payload_byte;
        logic [3:0]  payload_length;
        logic [15:0] dest_address;
        logic        group_address;
        logic [3:0]  apci_code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

### hw/rtl/knx_front.sv
`default_nettype none

module knx_front
    import knx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   payload_byte,
    input  wire logic [3:0]   payload_length,
    input  wire logic [15:0]  dest_address,
    input  wire logic         group_address,
    input  wire logic [3:0]   apci_code,
    input  wire fifo_status_t fifo_status,
    output logic              push,
    output cmd_t              cmd
);

    logic [3:0] bytes_left_reg;
    logic [3:0] bytes_left_next;
    logic       idle;

    assign in_stall = fifo_status.full;
    assign push     = in_valid && !fifo_status.full;
    assign idle     = (bytes_left_reg == 4'd0);

    always_comb
    begin
        cmd.is_start       = idle;
        cmd.payload_byte   = payload_byte;
        cmd.payload_length = payload_length;
        cmd.dest_address   = dest_address;
        cmd.group_address  = group_address;
        cmd.apci_code      = apci_code;
        // A header closes at once when no payload transactions follow it.
        if (idle)
        begin
            cmd.close = (payload_length <= 4'd1);
        end
        else
        begin
            cmd.close = (bytes_left_reg == 4'd1);
        end
    end

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        if (push)
        begin
            if (idle)
            begin
                bytes_left_next = (payload_length <= 4'd1) ? 4'd0 : payload_length;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 4'd0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/knx_cmd_fifo.sv
`default_nettype none

module knx_cmd_fifo
    import knx_pkg::*;
#(
    parameter int DEPTH = KNX_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cmd_t    push_cmd,
    input  wire logic    pop,
    output cmd_t         head,
    output fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/knx_back.sv
`default_nettype none

module knx_back
    import knx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire cmd_t         head,
    input  wire fifo_status_t fifo_status,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [7:0]        frame_byte,
    output logic              end_of_frame
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] frame_byte_reg;
    logic [7:0] frame_byte_next;
    logic       end_of_frame_reg;
    logic       end_of_frame_next;
    logic       load;
    logic       last_octet;
    logic       is_check;
    logic [7:0] octet;

    assign load = !fifo_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load && last_octet;

    always_comb
    begin
        if (head.is_start)
        begin
            is_check   = (idx_reg == IDX_CHECK);
            last_octet = head.close ? (idx_reg == IDX_CHECK) : (idx_reg == IDX_APCI_LO);
        end
        else
        begin
            is_check   = (idx_reg == IDX_DATA_CHECK);
            last_octet = head.close ? (idx_reg == IDX_DATA_CHECK) : (idx_reg == IDX_PAYLOAD);
        end
    end

    always_comb
    begin
        octet = ~check_reg;
        if (head.is_start)
        begin
            unique case (idx_reg)
                IDX_CTRL:
                begin
                    octet = CTRL_BASE | {2'b00, cfg.repeat_flag, 1'b0, cfg.priority_cfg, 2'b00};
                end
                IDX_SRC_HI:  octet = cfg.source_address[15:8];
                IDX_SRC_LO:  octet = cfg.source_address[7:0];
                IDX_DST_HI:  octet = head.dest_address[15:8];
                IDX_DST_LO:  octet = head.dest_address[7:0];
                IDX_LEN:     octet = {head.group_address, 3'b000, head.payload_length};
                IDX_APCI_HI: octet = {6'b000000, head.apci_code[3:2]};
                IDX_APCI_LO:
                begin
                    // Six data bits ride in this octet only for a one-byte telegram.
                    octet = {head.apci_code[1:0],
                             (head.payload_length == 4'd1) ? head.payload_byte[5:0] : 6'b000000};
                end
                default:     octet = ~check_reg;
            endcase
        end
        else if (!is_check)
        begin
            octet = head.payload_byte;
        end
    end

    always_comb
    begin
        idx_next          = idx_reg;
        check_next        = check_reg;
        out_valid_next    = out_valid_reg && out_stall;
        frame_byte_next   = frame_byte_reg;
        end_of_frame_next = end_of_frame_reg;
        if (load)
        begin
            out_valid_next    = 1'b1;
            frame_byte_next   = octet;
            end_of_frame_next = is_check;
            check_next        = is_check ? 8'h00 : (check_reg ^ octet);
            idx_next          = last_octet ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            check_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_byte_reg   <= frame_byte_next;
        end_of_frame_reg <= end_of_frame_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_byte   = frame_byte_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule

`default_nettype wire

### hw/rtl/knx_frame_builder_top.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  payload_byte, payload_length, dest_address,
//                                           group_address, apci_code
// output    out        out_valid/out_stall  frame_byte, end_of_frame
// config    in         cfg_write_en         cfg_index, cfg_data
//
// A header transaction yields eight octets, or nine with the check octet.
// A payload transaction yields one octet, or two on the last one with the check octet.
// The octet sequencer in the back end sends one per cycle unless the output stalls; the
// command queue lets new transactions be taken while earlier ones are still being sent.
// Reset is asynchronous and active low; configuration returns to priority 3, no repeat,
// source address 0. A stalled output holds its octet while the sequencer waits.
`default_nettype none

`include "assert_macros.svh"

module knx_frame_builder_top
    import knx_pkg::*;
#(
    parameter int QUEUE_DEPTH = KNX_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [3:0]  payload_length,
    input  wire logic [15:0] dest_address,
    input  wire logic        group_address,
    input  wire logic [3:0]  apci_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             end_of_frame,
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    cmd_t         push_cmd;
    cmd_t         head;
    fifo_status_t fifo_status;
    logic         push;
    logic         pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PRIORITY: cfg_next.priority_cfg   = cfg_data[1:0];
                CFG_REPEAT:   cfg_next.repeat_flag    = cfg_data[0];
                CFG_SOURCE:   cfg_next.source_address = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priority_cfg   <= 2'd3;
            cfg_reg.repeat_flag    <= 1'b0;
            cfg_reg.source_address <= 16'h0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    knx_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .dest_address   (dest_address),
        .group_address  (group_address),
        .apci_code      (apci_code),
        .fifo_status    (fifo_status),
        .push           (push),
        .cmd            (push_cmd)
    );

    knx_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (fifo_status)
    );

    knx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .fifo_status  (fifo_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame)
    );

    `ASSERT_NOW(a_no_push_when_full, push, !fifo_status.full, "command pushed into a full queue")
    `ASSERT_NOW(a_no_pop_when_empty, pop, !fifo_status.empty, "command popped from an empty queue")
    `ASSERT_NEXT(a_accept_queues, push, !fifo_status.empty, "accepted transaction not queued")
    `ASSERT_NOW(a_out_from_queue, $rose(out_valid), $past(!fifo_status.empty),
                "output octet appeared without a queued command")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import knx_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 75;
    localparam int NUM_DIRECTED = 22;
    localparam int NO_FRAME     = -1;

    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic [7:0] value;
        logic       closing;
    } octet_t;

    typedef struct {
        logic [7:0]  pb;
        logic [3:0]  len;
        logic [15:0] dst;
        logic        grp;
        logic [3:0]  apci;
        int          known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = '0;
    logic [3:0]  payload_length = '0;
    logic [15:0] dest_address = '0;
    logic        group_address = 1'b0;
    logic [3:0]  apci_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        end_of_frame;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Shadow of the block: configuration and telegram progress.
    cfg_t        shadow_cfg;
    logic [3:0]  octets_owed;
    logic [7:0]  xor_so_far;

    octet_t      expected_octets[$];
    octet_t      encoded[$];
    int          known_tags[$];
    logic [7:0]  known_frames[2][9];
    stim_row_t   directed_rows[NUM_DIRECTED];

    int          cycle_count = 0;
    int          mismatches = 0;
    int          octets_checked = 0;
    int          telegrams = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int          settings_used = 0;
    int          burst_left = 0;
    bit          valid_up = 1'b0;
    bit          hold_request = 1'b0;

    knx_frame_builder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .dest_address   (dest_address),
        .group_address  (group_address),
        .apci_code      (apci_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .end_of_frame   (end_of_frame),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d octets outstanding.",
                     cycle_count, expected_octets.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic emit_octet(input logic [7:0] value);
        encoded.push_back('{value, 1'b0});
        xor_so_far = xor_so_far ^ value;
    endtask

    task automatic emit_check();
        encoded.push_back('{~xor_so_far, 1'b1});
        xor_so_far  = '0;
        octets_owed = '0;
    endtask

    // Computes the octets one input transaction causes and advances the shadow state.
    task automatic encode_transaction(input logic [7:0] pb, input logic [3:0] len,
                                      input logic [15:0] dst, input logic grp,
                                      input logic [3:0] apci);
        logic [7:0] apci_lo;
        encoded.delete();
        if (octets_owed != 0)
        begin
            emit_octet(pb);
            octets_owed = octets_owed - 4'd1;
            if (octets_owed == 0)
                emit_check();
        end
        else
        begin
            telegrams++;
            xor_so_far = '0;
            emit_octet(CTRL_BASE | {2'b00, shadow_cfg.repeat_flag, 1'b0,
                                    shadow_cfg.priority_cfg, 2'b00});
            emit_octet(shadow_cfg.source_address[15:8]);
            emit_octet(shadow_cfg.source_address[7:0]);
            emit_octet(dst[15:8]);
            emit_octet(dst[7:0]);
            emit_octet({grp, 3'b000, len});
            emit_octet({6'b000000, apci[3:2]});
            apci_lo = {apci[1:0], 6'b000000};
            if (len == 4'd1)
                apci_lo = apci_lo | {2'b00, pb[5:0]};
            emit_octet(apci_lo);
            if (len <= 4'd1)
                emit_check();
            else
                octets_owed = len;
        end
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_PRIORITY: shadow_cfg.priority_cfg = data[1:0];
            CFG_REPEAT:   shadow_cfg.repeat_flag = data[0];
            CFG_SOURCE:   shadow_cfg.source_address = data;
            default:      ;
        endcase
    endtask

    task automatic take_input();
        int tag;
        tag = NO_FRAME;
        if (known_tags.size() != 0)
            tag = known_tags.pop_front();
        encode_transaction(payload_byte, payload_length, dest_address, group_address,
                           apci_code);
        if (tag != NO_FRAME)
        begin
            for (int i = 0; i < 9; i++)
                expected_octets.push_back('{known_frames[tag][i], i == 8});
        end
        else
        begin
            foreach (encoded[i])
                expected_octets.push_back(encoded[i]);
        end
    endtask

    task automatic check_output();
        octet_t want;
        if (expected_octets.size() == 0)
        begin
            report_mismatch($sformatf("unexpected octet %02h eof %0b", frame_byte,
                                      end_of_frame));
        end
        else
        begin
            want = expected_octets.pop_front();
            if (frame_byte !== want.value)
                report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                          frame_byte, want.value));
            if (end_of_frame !== want.closing)
                report_mismatch($sformatf("end_of_frame %0b, expected %0b",
                                          end_of_frame, want.closing));
            octets_checked++;
        end
    endtask

    // Input before output: a result never leaves in the cycle its transaction enters.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_cfg  = '{priority_cfg: 2'd3, repeat_flag: 1'b0, source_address: 16'h0000};
            octets_owed = '0;
            xor_so_far  = '0;
        end
        else
        begin
            if (cfg_write_en)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                take_input();
            if (out_valid && !out_stall)
                check_output();
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off on request.
    initial
    begin
        int mode;
        int mode_left;
        int hold_count;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= (tick % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [7:0] pb, input logic [3:0] len,
                             input logic [15:0] dst, input logic grp,
                             input logic [3:0] apci, input int known);
        known_tags.push_back(known);
        payload_byte   <= pb;
        payload_length <= len;
        dest_address   <= dst;
        group_address  <= grp;
        apci_code      <= apci;
        in_valid       <= 1'b1;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (burst_left == 0)
        begin
            // Mostly short bursts; once in a while a long run with no gaps.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic idle_sender();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (expected_octets.size() != 0 || known_tags.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index    <= idx;
        cfg_data     <= data;
        cfg_write_en <= 1'b1;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic configure(input logic [1:0] prio, input logic rep, input logic [15:0] src);
        idle_sender();
        wait_drained();
        write_reg(CFG_PRIORITY, {14'($urandom), prio});
        write_reg(CFG_REPEAT, {15'($urandom), rep});
        write_reg(CFG_SOURCE, src);
        write_reg(CFG_NONE, 16'($urandom));
        settings_used++;
    endtask

    // Lengths lean short; the payload transactions carry random noise in the
    // fields that the block ignores while a telegram is open.
    task automatic send_telegram();
        int pick;
        logic [3:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            len = 4'($urandom_range(0, 1));
        else if (pick < 80)
            len = 4'($urandom_range(2, 5));
        else
            len = 4'($urandom_range(6, 15));
        send_item(8'($urandom), len, 16'($urandom), 1'($urandom), 4'($urandom), NO_FRAME);
        if (len >= 4'd2)
        begin
            for (int i = 0; i < int'(len); i++)
                send_item(8'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
                          4'($urandom), NO_FRAME);
        end
    endtask

    task automatic run_phase();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < PHASE_ITEMS)
            send_telegram();
    endtask

    function automatic stim_row_t make_row(input logic [7:0] pb, input logic [3:0] len,
                                           input logic [15:0] dst, input logic grp,
                                           input logic [3:0] apci, input int known);
        stim_row_t row;
        row.pb = pb;
        row.len = len;
        row.dst = dst;
        row.grp = grp;
        row.apci = apci;
        row.known = known;
        return row;
    endfunction

    initial
    begin
        // Telegrams under the reset settings: priority 3, no repeat, source 0.
        known_frames[0] = '{8'h9C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h63};
        known_frames[1] = '{8'h9C, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h81, 8'h03, 8'hFF, 8'h1E};

        // Empty telegram, all-ones single-octet telegram, then a full-length one whose
        // payload transactions carry extreme and mixed values in every ignored field.
        directed_rows[0]  = make_row(8'h00, 4'd0,  16'h0000, 1'b0, 4'h0, 0);
        directed_rows[1]  = make_row(8'hFF, 4'd1,  16'hFFFF, 1'b1, 4'hF, 1);
        directed_rows[2]  = make_row(8'h3C, 4'd15, 16'h1234, 1'b0, 4'hA, NO_FRAME);
        directed_rows[3]  = make_row(8'h00, 4'd0,  16'h0000, 1'b0, 4'h0, NO_FRAME);
        directed_rows[4]  = make_row(8'hFF, 4'd15, 16'hFFFF, 1'b1, 4'hF, NO_FRAME);
        directed_rows[5]  = make_row(8'hAA, 4'd1,  16'h0000, 1'b1, 4'h0, NO_FRAME);
        directed_rows[6]  = make_row(8'h55, 4'd0,  16'hFFFF, 1'b0, 4'hF, NO_FRAME);
        directed_rows[7]  = make_row(8'h01, 4'd15, 16'h0000, 1'b1, 4'h5, NO_FRAME);
        directed_rows[8]  = make_row(8'h80, 4'd1,  16'hFFFF, 1'b0, 4'hA, NO_FRAME);
        directed_rows[9]  = make_row(8'h7F, 4'd0,  16'h8000, 1'b1, 4'h1, NO_FRAME);
        directed_rows[10] = make_row(8'hFE, 4'd15, 16'h0001, 1'b0, 4'h8, NO_FRAME);
        directed_rows[11] = make_row(8'h0F, 4'd1,  16'h00FF, 1'b1, 4'h3, NO_FRAME);
        directed_rows[12] = make_row(8'hF0, 4'd0,  16'hFF00, 1'b0, 4'hC, NO_FRAME);
        directed_rows[13] = make_row(8'h33, 4'd15, 16'h5555, 1'b1, 4'h6, NO_FRAME);
        directed_rows[14] = make_row(8'hCC, 4'd1,  16'hAAAA, 1'b0, 4'h9, NO_FRAME);
        directed_rows[15] = make_row(8'h96, 4'd0,  16'hFFFF, 1'b1, 4'hF, NO_FRAME);
        directed_rows[16] = make_row(8'h69, 4'd15, 16'h0000, 1'b0, 4'h0, NO_FRAME);
        directed_rows[17] = make_row(8'hC3, 4'd2,  16'h1111, 1'b1, 4'h7, NO_FRAME);
        directed_rows[18] = make_row(8'hC0, 4'd2,  16'hA5C3, 1'b1, 4'h5, NO_FRAME);
        directed_rows[19] = make_row(8'h7E, 4'd0,  16'hFFFF, 1'b0, 4'hF, NO_FRAME);
        directed_rows[20] = make_row(8'h81, 4'd15, 16'h0000, 1'b1, 4'h0, NO_FRAME);
        // Single-octet telegram whose upper payload bits must be dropped.
        directed_rows[21] = make_row(8'hC0, 4'd1,  16'h8001, 1'b0, 4'h0, NO_FRAME);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].pb, directed_rows[i].len, directed_rows[i].dst,
                      directed_rows[i].grp, directed_rows[i].apci, directed_rows[i].known);

        configure(2'd0, 1'b0, 16'h0000);
        run_phase();

        // The receiver holds off while transactions keep coming, so the queue fills.
        configure(2'd3, 1'b1, 16'hFFFF);
        hold_request = 1'b1;
        run_phase();

        configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom));
        run_phase();

        configure(2'd2, 1'b0, 16'($urandom));
        run_phase();

        idle_sender();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_octets.size() != 0)
            report_mismatch($sformatf("%0d octets never arrived", expected_octets.size()));

        $display("Sent %0d transactions in %0d telegrams; checked %0d octets.",
                 items_sent, telegrams, octets_checked);
        $display("Applied %0d register writes over %0d settings, with one long output hold.",
                 reg_writes, settings_used);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
